// ===== rtl/sgpf_pkg.sv =====
// Shared types and constants for the servo goal packet framer.
package sgpf_pkg;

	typedef struct packed {
		logic [7:0] servo_id;
		logic [9:0] goal_angle;
		logic [9:0] move_speed;
	} cmd_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} pkt_t;

	typedef struct packed {
		logic [7:0]  servo_id;
		logic [11:0] pos;
		logic [9:0]  speed;
		logic [7:0]  chk;
		logic        deg;
		logic [1:0]  reps_m1;
	} desc_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP         = 2'd2;

	localparam logic [7:0] HDR_BYTE    = 8'hFF;
	localparam logic [7:0] PKT_LEN     = 8'h07;
	localparam logic [7:0] INSTR_WRITE = 8'h03;
	localparam logic [7:0] GOAL_REG    = 8'h1E;

	localparam logic [4:0] RAW_HDR  = 5'd2;
	localparam logic [4:0] DEG_HDR  = 5'd8;
	localparam logic [4:0] RAW_LAST = 5'd10;
	localparam logic [4:0] DEG_LAST = 5'd16;

	localparam logic [4:0] BODY_ID     = 5'd0;
	localparam logic [4:0] BODY_LEN    = 5'd1;
	localparam logic [4:0] BODY_INSTR  = 5'd2;
	localparam logic [4:0] BODY_REG    = 5'd3;
	localparam logic [4:0] BODY_POS_L  = 5'd4;
	localparam logic [4:0] BODY_POS_H  = 5'd5;
	localparam logic [4:0] BODY_SPD_L  = 5'd6;
	localparam logic [4:0] BODY_SPD_H  = 5'd7;
	localparam logic [4:0] BODY_CHK    = 5'd8;

	localparam logic [2:0] MAX_REPEAT = 3'd4;

	// floor(4a/10) == (a * RECIP) >> RECIP_SHIFT for every 10-bit a
	localparam logic [11:0] RECIP       = 12'd3277;
	localparam int          RECIP_SHIFT = 13;

	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = 1;
	localparam int QCOUNT_W = 2;

endpackage

// ===== rtl/servo_goal_packet_framer_unit.sv =====
// Top level of the servo goal packet framer.
//
// Commands (servo id, goal angle, speed) enter on the cmd channel and leave
// as a byte stream on the pkt channel, one byte per accepted pkt item, with
// last_byte set on the final byte that a command causes. Both channels use
// valid/ready. The config port writes degree_mode, repeat_count and stop by
// index; the user must write them only while the block is idle, which the
// block does not enforce. A raw-mode command gives 11 bytes times repeat_count
// (0 counts as 1, above 4 as 4); a degree-mode command gives 17 bytes, or
// none while stop is set. The byte sequencer emits one byte per cycle while
// pkt_ready allows, and packets of successive commands follow with no gap
// when the next descriptor is queued. A command passes the front-end stage
// register, then the two-entry descriptor queue, which lets commands keep
// arriving while a packet streams out, then the sequencer. Reset clears the
// queue and the output register and sets the config registers to raw mode,
// one repeat, stop off. When the receiver holds pkt_ready low, the current
// byte holds and the queue fills, then cmd_ready drops.
module servo_goal_packet_framer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  sgpf_pkg::cmd_t                  cmd,
	output logic                            pkt_valid,
	input  logic                            pkt_ready,
	output sgpf_pkg::pkt_t                  pkt,
	input  logic                            cfg_we,
	input  logic [sgpf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sgpf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sgpf_pkg::*;

	logic  push_valid;
	logic  push_ready;
	desc_t push_data;
	logic  q_valid;
	logic  q_ready;
	desc_t q_data;

	sgpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sgpf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_data),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_data)
	);

	sgpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt)
	);

endmodule

// ===== rtl/sgpf_front.sv =====
// Front end: config registers, command intake, angle scaling and checksum.
module sgpf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  sgpf_pkg::cmd_t                 cmd,
	input  logic                           cfg_we,
	input  logic [sgpf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sgpf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           push_valid,
	input  logic                           push_ready,
	output sgpf_pkg::desc_t                push_data
);
	import sgpf_pkg::*;

	logic       degree_mode_q;
	logic [2:0] repeat_count_q;
	logic       stop_q;

	logic       valid_s1;
	logic       drop_s1;
	logic       deg_s1;
	logic [1:0] reps_s1;
	logic [7:0] id_s1;
	logic [9:0] angle_s1;
	logic [9:0] speed_s1;
	logic [8:0] quot_s1;

	logic [21:0] prod;
	logic [1:0]  reps_m1;
	logic        advance;
	logic [11:0] pos;
	logic [7:0]  sum;

	assign prod = 22'(cmd.goal_angle) * 22'(RECIP);

	always_comb begin
		if (repeat_count_q == 3'd0) begin
			reps_m1 = 2'd0;
		end else if (repeat_count_q > MAX_REPEAT) begin
			reps_m1 = 2'd3;
		end else begin
			reps_m1 = 2'(repeat_count_q - 3'd1);
		end
	end

	assign advance    = drop_s1 || push_ready;
	assign cmd_ready  = !valid_s1 || advance;
	assign push_valid = valid_s1 && !drop_s1;

	always_comb begin
		if (deg_s1) begin
			pos = {1'b0, angle_s1, 1'b0} + 12'(angle_s1) + 12'(quot_s1);
		end else begin
			pos = 12'(angle_s1);
		end
		sum = id_s1 + PKT_LEN + INSTR_WRITE + GOAL_REG + pos[7:0] + {4'b0, pos[11:8]}
			+ speed_s1[7:0] + {6'b0, speed_s1[9:8]};
	end

	assign push_data = '{servo_id: id_s1, pos: pos, speed: speed_s1, chk: ~sum,
		deg: deg_s1, reps_m1: reps_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_mode_q  <= 1'b0;
			repeat_count_q <= 3'd1;
			stop_q         <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DEGREE_MODE:  degree_mode_q  <= cfg_data[0];
				CFG_REPEAT_COUNT: repeat_count_q <= cfg_data;
				CFG_STOP:         stop_q         <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			drop_s1  <= degree_mode_q && stop_q;
			deg_s1   <= degree_mode_q;
			reps_s1  <= degree_mode_q ? 2'd0 : reps_m1;
			id_s1    <= cmd.servo_id;
			angle_s1 <= cmd.goal_angle;
			speed_s1 <= cmd.move_speed;
			quot_s1  <= prod[RECIP_SHIFT+8:RECIP_SHIFT];
		end
	end

endmodule

// ===== rtl/sgpf_queue.sv =====
// Short descriptor queue between the front end and the byte sequencer.
module sgpf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  sgpf_pkg::desc_t wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output sgpf_pkg::desc_t rd_data
);
	import sgpf_pkg::*;

	desc_t                mem_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QCOUNT_W-1:0]  count_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = count_q != QCOUNT_W'(QDEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCOUNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == QCOUNT_W'(QDEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("push lost");

endmodule

// ===== rtl/sgpf_back.sv =====
// Back end: walks each descriptor byte by byte into the output register.
module sgpf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  sgpf_pkg::desc_t q_data,
	output logic            pkt_valid,
	input  logic            pkt_ready,
	output sgpf_pkg::pkt_t  pkt
);
	import sgpf_pkg::*;

	logic       busy_q;
	logic       out_valid_q;
	pkt_t       out_q;
	desc_t      cur_q;
	logic [4:0] idx_q;
	logic [1:0] rep_q;

	logic       adv;
	logic       emit;
	logic       final_c;
	logic       load;
	logic [4:0] hdr;
	logic [4:0] last_idx;
	logic [4:0] body_idx;
	logic [7:0] byte_c;

	assign hdr      = cur_q.deg ? DEG_HDR : RAW_HDR;
	assign last_idx = cur_q.deg ? DEG_LAST : RAW_LAST;
	assign body_idx = idx_q - hdr;
	assign adv      = !out_valid_q || pkt_ready;
	assign emit     = busy_q && adv;
	assign final_c  = (idx_q == last_idx) && (rep_q == cur_q.reps_m1);
	assign load     = (!busy_q || (emit && final_c)) && q_valid;
	assign q_ready  = load;

	always_comb begin
		if (idx_q < hdr) begin
			byte_c = HDR_BYTE;
		end else begin
			case (body_idx)
				BODY_ID:    byte_c = cur_q.servo_id;
				BODY_LEN:   byte_c = PKT_LEN;
				BODY_INSTR: byte_c = INSTR_WRITE;
				BODY_REG:   byte_c = GOAL_REG;
				BODY_POS_L: byte_c = cur_q.pos[7:0];
				BODY_POS_H: byte_c = {4'b0, cur_q.pos[11:8]};
				BODY_SPD_L: byte_c = cur_q.speed[7:0];
				BODY_SPD_H: byte_c = {6'b0, cur_q.speed[9:8]};
				BODY_CHK:   byte_c = cur_q.chk;
				default:    byte_c = HDR_BYTE;
			endcase
		end
	end

	assign pkt_valid = out_valid_q;
	assign pkt       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && final_c) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= '{tx_byte: byte_c, last_byte: final_c};
		end
		if (load) begin
			cur_q <= q_data;
			idx_q <= '0;
			rep_q <= '0;
		end else if (emit) begin
			if (idx_q == last_idx) begin
				idx_q <= '0;
				rep_q <= rep_q + 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= last_idx)
		else $error("byte index past packet end");

	a_deg_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cur_q.deg |-> rep_q == 2'd0)
		else $error("degree packet repeated");

	a_idle_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		emit && final_c && !q_valid |=> !busy_q)
		else $error("sequencer busy after final byte");

endmodule

// ===== tb/sv/packet_byte_checker.sv =====
// Checker for the servo goal packet framer: predicts the byte stream of each command.
`timescale 1ns / 100ps

module packet_byte_checker
	import sgpf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic                 cmd_ready,
	input  cmd_t                 cmd,
	input  logic                 pkt_valid,
	input  logic                 pkt_ready,
	input  pkt_t                 pkt,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                   mismatch_count,
	output int                   bytes_outstanding
);

	logic       deg_mode;
	logic [2:0] repeat_cnt;
	logic       stop_bit;
	pkt_t       expected_bytes[$];

	function automatic void frame_command(cmd_t c);
		logic [15:0] pos;
		logic [7:0]  body[9];
		logic [7:0]  sum;
		pkt_t        b;
		int          hdr_len;
		int          reps;
		int          total;
		int          n;
		if (deg_mode && stop_bit) begin
			return;
		end
		if (deg_mode) begin
			pos = 16'(c.goal_angle) * 16'd3 + (16'(c.goal_angle) * 16'd4) / 16'd10;
			hdr_len = int'(DEG_HDR);
			reps = 1;
		end else begin
			pos = 16'(c.goal_angle);
			hdr_len = int'(RAW_HDR);
			if (repeat_cnt == 3'd0)
				reps = 1;
			else if (repeat_cnt > MAX_REPEAT)
				reps = int'(MAX_REPEAT);
			else
				reps = int'(repeat_cnt);
		end
		body[0] = c.servo_id;
		body[1] = PKT_LEN;
		body[2] = INSTR_WRITE;
		body[3] = GOAL_REG;
		body[4] = pos[7:0];
		body[5] = pos[15:8];
		body[6] = c.move_speed[7:0];
		body[7] = {6'b0, c.move_speed[9:8]};
		sum = 8'd0;
		for (int i = 0; i < 8; i++)
			sum += body[i];
		body[8] = ~sum;
		total = reps * (hdr_len + 9);
		n = 0;
		for (int r = 0; r < reps; r++) begin
			for (int k = 0; k < hdr_len + 9; k++) begin
				n++;
				b.tx_byte = (k < hdr_len) ? HDR_BYTE : body[k - hdr_len];
				b.last_byte = (n == total);
				expected_bytes.push_back(b);
			end
		end
	endfunction

	task automatic note_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pkt_t want;
		if (!arst_n) begin
			deg_mode = 1'b0;
			repeat_cnt = 3'd1;
			stop_bit = 1'b0;
			expected_bytes.delete();
			mismatch_count = 0;
			bytes_outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_DEGREE_MODE:  deg_mode = cfg_data[0];
					CFG_REPEAT_COUNT: repeat_cnt = cfg_data;
					CFG_STOP:         stop_bit = cfg_data[0];
					default: ;
				endcase
			end
			if (pkt_valid && pkt_ready) begin
				if (expected_bytes.size() == 0) begin
					note_failure($sformatf("unexpected item tx_byte=%02h last_byte=%0b",
						pkt.tx_byte, pkt.last_byte));
				end else begin
					want = expected_bytes.pop_front();
					if (pkt.tx_byte !== want.tx_byte)
						note_failure($sformatf("tx_byte expected %02h actual %02h",
							want.tx_byte, pkt.tx_byte));
					if (pkt.last_byte !== want.last_byte)
						note_failure($sformatf("last_byte expected %0b actual %0b (tx_byte %02h)",
							want.last_byte, pkt.last_byte, want.tx_byte));
				end
			end
			if (cmd_valid && cmd_ready)
				frame_command(cmd);
			bytes_outstanding = expected_bytes.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the servo goal packet framer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
	import sgpf_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_ready;
	cmd_t                  cmd;
	logic                  pkt_valid;
	logic                  pkt_ready;
	pkt_t                  pkt;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatch_count;
	int                    bytes_outstanding;
	int                    send_idle_pct;
	int                    recv_idle_pct;
	int                    hold_off_cycles;

	servo_goal_packet_framer_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.pkt_valid(pkt_valid),
		.pkt_ready(pkt_ready),
		.pkt      (pkt),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	packet_byte_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_ready        (cmd_ready),
		.cmd              (cmd),
		.pkt_valid        (pkt_valid),
		.pkt_ready        (pkt_ready),
		.pkt              (pkt),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_data         (cfg_data),
		.mismatch_count   (mismatch_count),
		.bytes_outstanding(bytes_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		pkt_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				pkt_ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				pkt_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [9:0] random_ten_bit();
		case ($urandom_range(7))
			0:       return 10'd0;
			1:       return 10'h3FF;
			default: return 10'($urandom_range(1023));
		endcase
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		c.servo_id = 8'($urandom_range(255));
		c.goal_angle = random_ten_bit();
		c.move_speed = random_ten_bit();
		return c;
	endfunction

	task automatic send_cmd(cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (bytes_outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic       deg_sel;
		logic [2:0] rep_sel;
		logic       stop_sel;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		send_idle_pct = 31;
		recv_idle_pct = 76;
		hold_off_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(cmd_t'{8'd0, 10'd0, 10'd0});
		send_cmd(cmd_t'{8'd254, 10'h3FF, 10'h3FF});
		send_cmd(cmd_t'{8'd255, 10'h155, 10'h2AA});
		set_register(CFG_STOP, 3'd1);
		send_cmd(cmd_t'{8'd1, 10'd512, 10'd256});
		set_register(CFG_STOP, 3'd0);
		set_register(CFG_REPEAT_COUNT, 3'd0);
		send_cmd(cmd_t'{8'd2, 10'd1, 10'd1});
		set_register(CFG_REPEAT_COUNT, 3'd2);
		send_cmd(cmd_t'{8'd3, 10'd100, 10'd200});
		set_register(CFG_REPEAT_COUNT, 3'd3);
		send_cmd(cmd_t'{8'd4, 10'd255, 10'd256});
		set_register(CFG_REPEAT_COUNT, 3'd4);
		send_cmd(cmd_t'{8'd5, 10'h2AA, 10'h155});
		set_register(CFG_REPEAT_COUNT, 3'd5);
		send_cmd(cmd_t'{8'd6, 10'd767, 10'd768});
		set_register(CFG_REPEAT_COUNT, 3'd7);
		send_cmd(cmd_t'{8'd7, 10'h3FF, 10'd0});
		set_register(CFG_REPEAT_COUNT, 3'd1);
		set_register(CFG_DEGREE_MODE, 3'd1);
		set_register(CFG_STOP, 3'd1);
		send_cmd(cmd_t'{8'd8, 10'd300, 10'd5});
		send_cmd(cmd_t'{8'd9, 10'h3FF, 10'h3FF});
		set_register(CFG_STOP, 3'd0);
		send_cmd(cmd_t'{8'd10, 10'd0, 10'd0});
		send_cmd(cmd_t'{8'd11, 10'h3FF, 10'h3FF});
		send_cmd(cmd_t'{8'd12, 10'd300, 10'd1000});
		send_cmd(cmd_t'{8'd13, 10'd9, 10'd1});
		send_cmd(cmd_t'{8'd14, 10'd1, 10'd2});
		send_cmd(cmd_t'{8'd254, 10'd999, 10'd513});

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 76;
				end
				1: begin
					send_idle_pct = 76;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				deg_sel = 1'($urandom_range(1));
				rep_sel = 3'($urandom_range(7));
				stop_sel = ($urandom_range(4) == 0);
				if (mode == 2 && blk == 0) begin
					deg_sel = 1'b0;
					rep_sel = 3'd4;
				end
				set_register(CFG_DEGREE_MODE, {2'b0, deg_sel});
				set_register(CFG_REPEAT_COUNT, rep_sel);
				set_register(CFG_STOP, {2'b0, stop_sel});
				if (mode == 2 && blk == 0)
					hold_off_cycles = 400;
				repeat (35) send_cmd(random_command());
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && bytes_outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sgpf_pkg.sv
rtl/sgpf_front.sv
rtl/sgpf_queue.sv
rtl/sgpf_back.sv
rtl/servo_goal_packet_framer_unit.sv
tb/sv/packet_byte_checker.sv
tb/sv/tb_top.sv
